// ===== design/rgba_blit_pkg.sv =====
// ----------------------------------------------------------------------------
// rgba_blit_pkg
// Shared types and constants of the RGBA32 blit/blend/fill pixel engine.
// ----------------------------------------------------------------------------
package rgba_blit_pkg;

    localparam int XY_BITS       = 16;
    localparam int PIX_BITS      = 32;
    localparam int OFS_W         = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam int COORD_BITS_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 24;

    // register map
    localparam logic [CFG_IDX_BITS-1:0] CFG_REQ_RECT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_RECT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEST_IMAGE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_IMAGE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_ORIGIN  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FILL_COLOR  = 3'd5;

    localparam logic FUNC_BLEND = 1'b0;
    localparam logic FUNC_FILL  = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [2:0] {
        ST_WRITTEN  = 3'd0,
        ST_CLIPPED  = 3'd1,
        ST_SRC_OUT  = 3'd2,
        ST_TRANSP   = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        logic                       func;
        logic signed [XY_BITS-1:0]  dest_x;
        logic signed [XY_BITS-1:0]  dest_y;
        logic [PIX_BITS-1:0]        source_pixel;
        logic [PIX_BITS-1:0]        dest_pixel;
    } rgba_in_t;

    typedef struct packed {
        logic                 write_enable;
        logic [OFS_W-1:0]     dest_offset;
        logic [OFS_W-1:0]     source_offset;
        logic [PIX_BITS-1:0]  pixel_out;
        status_t              status;
    } rgba_out_t;

endpackage

// ===== design/rgba_blit_ofs.sv =====
// ----------------------------------------------------------------------------
// rgba_blit_ofs
// Byte offset of a point inside an image and check that it fits the limit.
// ----------------------------------------------------------------------------
module rgba_blit_ofs
    import rgba_blit_pkg::*;
#(
    parameter int W  = 19,
    parameter int LB = 24
) (
    input  logic signed [W-1:0]  pt_x,
    input  logic signed [W-1:0]  pt_y,
    input  logic signed [W-1:0]  org_x,
    input  logic signed [W-1:0]  org_y,
    input  logic [LB:0]          pitch_sat,
    output logic                 ok,
    output logic [OFS_W-1:0]     ofs
);

    localparam int EW = (W + 2 > LB + 1) ? W + 2 : LB + 1;

    logic signed [W-1:0] row_d;
    logic signed [W-1:0] col_d;
    logic [EW-1:0]       row_e;
    logic [EW-1:0]       col_e;
    logic [LB:0]         row_s;
    logic [LB:0]         col_s;
    logic [2*LB+1:0]     prod;
    logic [2*LB+2:0]     sum;

    // operands saturate at the limit, so the product stays narrow
    always_comb begin
        row_d = pt_y - org_y;
        col_d = pt_x - org_x;
        row_e = EW'($unsigned(row_d));
        col_e = EW'($unsigned(col_d)) << 2;
        row_s = (|row_e[EW-1:LB]) ? {1'b1, {LB{1'b0}}} : {1'b0, row_e[LB-1:0]};
        col_s = (|col_e[EW-1:LB]) ? {1'b1, {LB{1'b0}}} : {1'b0, col_e[LB-1:0]};
        prod  = row_s * pitch_sat;
        sum   = {1'b0, prod} + (2*LB+3)'(col_s);
        ok    = ~|sum[2*LB+2:LB];
        ofs   = OFS_W'(sum[LB-1:0]);
    end

endmodule

// ===== design/rgba_blit_mix.sv =====
// ----------------------------------------------------------------------------
// rgba_blit_mix
// Straight-alpha source-over-destination blend of one RGBA32 pixel.
// ----------------------------------------------------------------------------
module rgba_blit_mix
    import rgba_blit_pkg::*;
(
    input  logic [PIX_BITS-1:0] src,
    input  logic [PIX_BITS-1:0] dst,
    output logic [PIX_BITS-1:0] pix
);

    // exact floor(v / 255) for v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'd1 + {9'b0, v[15:8]};
        return t[15:8];
    endfunction

    logic [7:0]  a;
    logic [7:0]  ia;
    logic [15:0] acc [3];
    logic [15:0] da_acc;
    logic [PIX_BITS-1:0] blend;

    always_comb begin
        a  = src[31:24];
        ia = ALPHA_OPAQUE - a;
        for (int k = 0; k < 3; k++) begin
            acc[k] = 16'(src[8*k +: 8]) * 16'(a) + 16'(dst[8*k +: 8]) * 16'(ia);
            blend[8*k +: 8] = div255(acc[k]);
        end
        da_acc = 16'(dst[31:24]) * 16'(ia);
        blend[31:24] = a + div255(da_acc);
        pix = (a == ALPHA_OPAQUE) ? src : blend;
    end

endmodule

// ===== design/rgba32_blit_blend_fill_pixel.sv =====
// ----------------------------------------------------------------------------
// rgba32_blit_blend_fill_pixel
// Per-pixel engine of a 2D RGBA32 blitter: clip, fill or alpha blend, and
// destination/source byte offsets.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s_       in   s_valid / s_ready      s_data  (rgba_in_t)
//  m_       out  m_valid / m_ready      m_data  (rgba_out_t)
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  One pixel per clock sustained while m_ready is high; an accepted pixel
//  enters the input register and then the result register, with the offset
//  multiply and blend between them. Clipped rectangle and image pitches are
//  registered from the configuration. Synchronous active-low reset clears
//  the valids and all configuration registers to zero. With m_ready low the
//  result holds, one more pixel waits in the input register, then s_ready drops.
// ----------------------------------------------------------------------------
module rgba32_blit_blend_fill_pixel
    import rgba_blit_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  rgba_in_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rgba_out_t                 m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int W  = ((CB > XY_BITS) ? CB : XY_BITS) + 3;
    localparam int LB = (OFFSET_BITS < OFS_W) ? OFFSET_BITS : OFS_W;
    localparam int EW = (W + 2 > LB + 1) ? W + 2 : LB + 1;

    // signed coordinate lane of a packed register, zero beyond its top
    function automatic logic signed [W-1:0] lane(input logic [63:0] r, input int idx);
        logic [64+CB-1:0] ext;
        logic [CB-1:0]    raw;
        ext = {{CB{1'b0}}, r} >> (idx * CB);
        raw = ext[CB-1:0];
        return $signed({{(W-CB){raw[CB-1]}}, raw});
    endfunction

    function automatic logic [LB:0] pitch_sat(input logic signed [W-1:0] lo,
                                              input logic signed [W-1:0] hi);
        logic signed [W-1:0] d;
        logic [EW-1:0]       e;
        d = hi - lo;
        e = EW'($unsigned(d)) << 2;
        return (|e[EW-1:LB]) ? {1'b1, {LB{1'b0}}} : {1'b0, e[LB-1:0]};
    endfunction

    // configuration
    logic [63:0]          req_rect_reg;
    logic [63:0]          clip_rect_reg;
    logic [63:0]          dest_image_reg;
    logic [63:0]          src_image_reg;
    logic [PIX_BITS-1:0]  src_origin_reg;
    logic [PIX_BITS-1:0]  fill_color_reg;

    // derived from configuration
    logic signed [W-1:0]  rx0_reg, ry0_reg, rx1_reg, ry1_reg;
    logic                 r_empty_reg;
    logic [LB:0]          di_pitch_reg, si_pitch_reg;
    logic signed [W-1:0]  rx0_next, ry0_next, rx1_next, ry1_next;

    logic signed [W-1:0]  dx0, dy0, dx1, dy1;
    logic signed [W-1:0]  cx0, cy0, cx1, cy1;
    logic signed [W-1:0]  ix0, iy0, ix1, iy1;
    logic signed [W-1:0]  sx0, sy0, sx1, sy1;
    logic signed [W-1:0]  org_x, org_y;

    // pipeline
    logic       in_vld_reg, in_vld_next;
    rgba_in_t   in_reg;
    logic       out_vld_reg, out_vld_next;
    rgba_out_t  out_reg, out_next;
    logic       out_take;

    logic signed [W-1:0]  px, py, sx, sy;
    logic                 in_r, in_di, in_si;
    logic                 d_ok, s_ok;
    logic [OFS_W-1:0]     d_ofs, s_ofs;
    logic [PIX_BITS-1:0]  mix_pix;
    status_t              st;

    always_comb begin
        dx0 = lane(req_rect_reg, 0);    dy0 = lane(req_rect_reg, 1);
        dx1 = lane(req_rect_reg, 2);    dy1 = lane(req_rect_reg, 3);
        cx0 = lane(clip_rect_reg, 0);   cy0 = lane(clip_rect_reg, 1);
        cx1 = lane(clip_rect_reg, 2);   cy1 = lane(clip_rect_reg, 3);
        ix0 = lane(dest_image_reg, 0);  iy0 = lane(dest_image_reg, 1);
        ix1 = lane(dest_image_reg, 2);  iy1 = lane(dest_image_reg, 3);
        sx0 = lane(src_image_reg, 0);   sy0 = lane(src_image_reg, 1);
        sx1 = lane(src_image_reg, 2);   sy1 = lane(src_image_reg, 3);
        org_x = lane({32'b0, src_origin_reg}, 0);
        org_y = lane({32'b0, src_origin_reg}, 1);
        rx0_next = (dx0 < cx0) ? cx0 : dx0;
        ry0_next = (dy0 < cy0) ? cy0 : dy0;
        rx1_next = (dx1 > cx1) ? cx1 : dx1;
        ry1_next = (dy1 > cy1) ? cy1 : dy1;
    end

    // handshake
    assign out_take     = !out_vld_reg || m_ready;
    assign s_ready      = !in_vld_reg || out_take;
    assign in_vld_next  = (s_valid && s_ready) || (in_vld_reg && !out_take);
    assign out_vld_next = in_vld_reg || (out_vld_reg && !m_ready);
    assign cfg_ready    = 1'b1;
    assign m_valid      = out_vld_reg;
    assign m_data       = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            req_rect_reg   <= '0;
            clip_rect_reg  <= '0;
            dest_image_reg <= '0;
            src_image_reg  <= '0;
            src_origin_reg <= '0;
            fill_color_reg <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REQ_RECT:   req_rect_reg   <= cfg_data;
                    CFG_CLIP_RECT:  clip_rect_reg  <= cfg_data;
                    CFG_DEST_IMAGE: dest_image_reg <= cfg_data;
                    CFG_SRC_IMAGE:  src_image_reg  <= cfg_data;
                    CFG_SRC_ORIGIN: src_origin_reg <= cfg_data[PIX_BITS-1:0];
                    CFG_FILL_COLOR: fill_color_reg <= cfg_data[PIX_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rx0_reg      <= rx0_next;
        ry0_reg      <= ry0_next;
        rx1_reg      <= rx1_next;
        ry1_reg      <= ry1_next;
        r_empty_reg  <= (rx0_next >= rx1_next) || (ry0_next >= ry1_next);
        di_pitch_reg <= pitch_sat(ix0, ix1);
        si_pitch_reg <= pitch_sat(sx0, sx1);
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (out_take && in_vld_reg) begin
            out_reg <= out_next;
        end
    end

    // per-pixel datapath
    always_comb begin
        px = $signed({{(W-XY_BITS){in_reg.dest_x[XY_BITS-1]}}, in_reg.dest_x});
        py = $signed({{(W-XY_BITS){in_reg.dest_y[XY_BITS-1]}}, in_reg.dest_y});
        sx = org_x + (px - rx0_reg);
        sy = org_y + (py - ry0_reg);
        in_r  = !r_empty_reg && px >= rx0_reg && px < rx1_reg
                && py >= ry0_reg && py < ry1_reg;
        in_di = px >= ix0 && px < ix1 && py >= iy0 && py < iy1;
        in_si = sx >= sx0 && sx < sx1 && sy >= sy0 && sy < sy1;
    end

    rgba_blit_ofs #(.W(W), .LB(LB)) u_dest_ofs (
        .pt_x      (px),
        .pt_y      (py),
        .org_x     (ix0),
        .org_y     (iy0),
        .pitch_sat (di_pitch_reg),
        .ok        (d_ok),
        .ofs       (d_ofs)
    );

    rgba_blit_ofs #(.W(W), .LB(LB)) u_src_ofs (
        .pt_x      (sx),
        .pt_y      (sy),
        .org_x     (sx0),
        .org_y     (sy0),
        .pitch_sat (si_pitch_reg),
        .ok        (s_ok),
        .ofs       (s_ofs)
    );

    rgba_blit_mix u_mix (
        .src (in_reg.source_pixel),
        .dst (in_reg.dest_pixel),
        .pix (mix_pix)
    );

    always_comb begin
        st = ST_WRITTEN;
        if (!in_r) begin
            st = ST_CLIPPED;
        end else if (in_reg.func == FUNC_FILL) begin
            if (!in_di) begin
                st = ST_CLIPPED;
            end else if (!d_ok) begin
                st = ST_OVERFLOW;
            end
        end else begin
            if (!in_si) begin
                st = ST_SRC_OUT;
            end else if (!in_di) begin
                st = ST_CLIPPED;
            end else if (!s_ok || !d_ok) begin
                st = ST_OVERFLOW;
            end else if (in_reg.source_pixel[31:24] == ALPHA_CLEAR) begin
                st = ST_TRANSP;
            end
        end

        out_next        = '0;
        out_next.status = st;
        if (st == ST_WRITTEN) begin
            out_next.write_enable  = 1'b1;
            out_next.dest_offset   = d_ofs;
            out_next.source_offset = (in_reg.func == FUNC_FILL) ? '0 : s_ofs;
            out_next.pixel_out     = (in_reg.func == FUNC_FILL) ? fill_color_reg : mix_pix;
        end
    end

    a_we_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.write_enable == (m_data.status == ST_WRITTEN)))
        else $error("write flag disagrees with status");

    a_skip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ST_WRITTEN) |->
        (m_data.pixel_out == '0 && m_data.dest_offset == '0 && m_data.source_offset == '0))
        else $error("skipped pixel carries nonzero payload");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && !out_take) |=> (in_vld_reg && $stable(in_reg)))
        else $error("waiting pixel lost or changed under stall");

    a_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_vld_reg)
        else $error("accepted transaction not held in input register");

    a_ofs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.dest_offset >> LB) == '0 && (m_data.source_offset >> LB) == '0))
        else $error("offset beyond configured limit");

endmodule
